@@ src/kld_pkg.sv @@
`default_nettype none
package kld_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W = 32;
  localparam int DET_W = 64;
  localparam int NUM_W = 100;
  localparam int QUO_W = 37;
  localparam int DIV_LAT = QUO_W + 1;
  localparam int LOG_FB = 28;
  localparam int LOG_W = LOG_FB + 6;
  localparam int LOG_LAT = LOG_FB + 2;
  localparam int LOG_DLY = DIV_LAT - LOG_LAT;
  localparam int SUM_W = 40;
  localparam logic [LOG_FB-1:0] LN2_Q28 = 28'hB17217F;
  localparam logic [QUO_W-1:0] R_CAP = {1'b1, {(QUO_W-1){1'b0}}};

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIX = 2'd1;
  localparam logic [1:0] ST_NONPD = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic nofix;
    logic nonpd;
  } kld_flags_t;

endpackage
`default_nettype wire

@@ src/kld_front.sv @@
`default_nettype none
module kld_front import kld_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic        [IN_W-1:0]  pf_mean_x,
  input  logic        [IN_W-1:0]  pf_mean_y,
  input  logic        [IN_W-1:0]  pf_var_x,
  input  logic        [IN_W-1:0]  pf_var_y,
  input  logic        [IN_W-1:0]  pf_cov_xy,
  input  logic        [IN_W-1:0]  fix_mean_x,
  input  logic        [IN_W-1:0]  fix_mean_y,
  input  logic        [IN_W-1:0]  fix_var_x,
  input  logic        [IN_W-1:0]  fix_var_y,
  input  logic        [IN_W-1:0]  fix_cov_xy,
  input  logic                    fix_valid,
  output logic                    out_valid,
  output kld_flags_t              out_flags,
  output logic        [NUM_W-1:0] num,
  output logic        [DET_W-1:0] detg,
  output logic        [DET_W-1:0] detp
);

  logic [IN_W:0]   dx_c, dy_c, dxn_c, dyn_c;
  logic [IN_W-1:0] dxm_c, dym_c, gcm_c, pcm_c;

  // stage 1: differences and magnitudes
  logic v1, neg5_1, neg6_1, nofix1;
  logic [IN_W-1:0] dxm1, dym1, gcm1, pcm1, gx1, gy1, px1, py1;
  // stage 2: 32x32 products
  logic v2, neg5_2, neg6_2, nofix2;
  logic [DET_W-1:0] gxgy2, gcsq2, pxpy2, pcsq2, dxsq2, dysq2, dxdy2, gypx2, gxpy2, gcpc2;
  logic [IN_W-1:0] gx2, gy2, gcm2;
  // stage 3: determinants and partial products
  logic v3, neg5_3, neg6_3, nofix3;
  logic [DET_W-1:0] detg3, detp3, gypx3, gxpy3, gcpc3;
  logic [DET_W-1:0] p2lo3, p2hi3, p4lo3, p4hi3, p6lo3, p6hi3;
  // stage 4: terms
  logic v4, neg5_4, neg6_4;
  kld_flags_t fl4;
  logic [NUM_W-1:0] t1, t2, t3, t4, t5, t6;
  logic [DET_W-1:0] detg4, detp4;
  // stage 5: partial sums
  logic v5;
  kld_flags_t fl5;
  logic [NUM_W-1:0] a5, b5, c5;
  logic [DET_W-1:0] detg5, detp5;

  always_comb begin
    dx_c  = {pf_mean_x[IN_W-1], pf_mean_x} - {fix_mean_x[IN_W-1], fix_mean_x};
    dy_c  = {pf_mean_y[IN_W-1], pf_mean_y} - {fix_mean_y[IN_W-1], fix_mean_y};
    dxn_c = -dx_c;
    dyn_c = -dy_c;
    dxm_c = dx_c[IN_W] ? dxn_c[IN_W-1:0] : dx_c[IN_W-1:0];
    dym_c = dy_c[IN_W] ? dyn_c[IN_W-1:0] : dy_c[IN_W-1:0];
    gcm_c = fix_cov_xy[IN_W-1] ? (~fix_cov_xy + 1'b1) : fix_cov_xy;
    pcm_c = pf_cov_xy[IN_W-1] ? (~pf_cov_xy + 1'b1) : pf_cov_xy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxm1   <= dxm_c;
      dym1   <= dym_c;
      gcm1   <= gcm_c;
      pcm1   <= pcm_c;
      gx1    <= fix_var_x;
      gy1    <= fix_var_y;
      px1    <= pf_var_x;
      py1    <= pf_var_y;
      neg5_1 <= fix_cov_xy[IN_W-1] == pf_cov_xy[IN_W-1];
      neg6_1 <= fix_cov_xy[IN_W-1] == (dx_c[IN_W] != dy_c[IN_W]);
      nofix1 <= ~fix_valid;

      gxgy2  <= DET_W'(gx1) * DET_W'(gy1);
      gcsq2  <= DET_W'(gcm1) * DET_W'(gcm1);
      pxpy2  <= DET_W'(px1) * DET_W'(py1);
      pcsq2  <= DET_W'(pcm1) * DET_W'(pcm1);
      dxsq2  <= DET_W'(dxm1) * DET_W'(dxm1);
      dysq2  <= DET_W'(dym1) * DET_W'(dym1);
      dxdy2  <= DET_W'(dxm1) * DET_W'(dym1);
      gypx2  <= DET_W'(gy1) * DET_W'(px1);
      gxpy2  <= DET_W'(gx1) * DET_W'(py1);
      gcpc2  <= DET_W'(gcm1) * DET_W'(pcm1);
      gx2    <= gx1;
      gy2    <= gy1;
      gcm2   <= gcm1;
      neg5_2 <= neg5_1;
      neg6_2 <= neg6_1;
      nofix2 <= nofix1;

      detg3  <= (gxgy2 > gcsq2) ? gxgy2 - gcsq2 : '0;
      detp3  <= (pxpy2 > pcsq2) ? pxpy2 - pcsq2 : '0;
      p2lo3  <= DET_W'(gy2) * DET_W'(dxsq2[31:0]);
      p2hi3  <= DET_W'(gy2) * DET_W'(dxsq2[63:32]);
      p4lo3  <= DET_W'(gx2) * DET_W'(dysq2[31:0]);
      p4hi3  <= DET_W'(gx2) * DET_W'(dysq2[63:32]);
      p6lo3  <= DET_W'(gcm2) * DET_W'(dxdy2[31:0]);
      p6hi3  <= DET_W'(gcm2) * DET_W'(dxdy2[63:32]);
      gypx3  <= gypx2;
      gxpy3  <= gxpy2;
      gcpc3  <= gcpc2;
      neg5_3 <= neg5_2;
      neg6_3 <= neg6_2;
      nofix3 <= nofix2;

      t1        <= NUM_W'(gypx3) << FRAC_BITS;
      t2        <= NUM_W'(p2lo3) + (NUM_W'(p2hi3) << 32);
      t3        <= NUM_W'(gxpy3) << FRAC_BITS;
      t4        <= NUM_W'(p4lo3) + (NUM_W'(p4hi3) << 32);
      t5        <= NUM_W'(gcpc3) << (FRAC_BITS + 1);
      t6        <= (NUM_W'(p6lo3) + (NUM_W'(p6hi3) << 32)) << 1;
      neg5_4    <= neg5_3;
      neg6_4    <= neg6_3;
      fl4.nofix <= nofix3;
      fl4.nonpd <= (detg3 == '0) || (detp3 == '0);
      detg4     <= detg3;
      detp4     <= detp3;

      a5    <= t1 + t2;
      b5    <= t3 + t4;
      c5    <= (neg5_4 ? -t5 : t5) + (neg6_4 ? -t6 : t6);
      fl5   <= fl4;
      detg5 <= detg4;
      detp5 <= detp4;

      num       <= a5 + b5 + c5;
      out_flags <= fl5;
      detg      <= detg5;
      detp      <= detp5;
    end
  end

endmodule
`default_nettype wire

@@ src/kld_div.sv @@
`default_nettype none
module kld_div import kld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  kld_flags_t       in_flags,
  input  logic [NUM_W-1:0] num,
  input  logic [DET_W-1:0] den,
  output logic             out_valid,
  output kld_flags_t       out_flags,
  output logic [QUO_W-1:0] quo,
  output logic             big
);

  localparam int REM_W = NUM_W - 1;
  localparam int CMP_W = DET_W + QUO_W;

  logic             v   [0:QUO_W];
  kld_flags_t       fl  [0:QUO_W];
  logic [REM_W-1:0] rem [0:QUO_W];
  logic [DET_W-1:0] dd  [0:QUO_W];
  logic [QUO_W-1:0] q   [0:QUO_W];
  logic             bg  [0:QUO_W];
  logic [REM_W-1:0] clamp;

  // negative numerator reads as zero
  assign clamp = num[NUM_W-1] ? '0 : num[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0]  <= in_flags;
      rem[0] <= clamp;
      dd[0]  <= den;
      q[0]   <= '0;
      bg[0]  <= CMP_W'(clamp) >= (CMP_W'(den) << QUO_W);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [CMP_W-1:0] ds;
    logic             ge;
    assign ds = CMP_W'(dd[k-1]) << (QUO_W - k);
    assign ge = CMP_W'(rem[k-1]) >= ds;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[k]  <= fl[k-1];
        rem[k] <= ge ? rem[k-1] - ds[REM_W-1:0] : rem[k-1];
        dd[k]  <= dd[k-1];
        q[k]   <= {q[k-1][QUO_W-2:0], ge};
        bg[k]  <= bg[k-1];
      end
    end
  end

  assign out_valid = v[QUO_W];
  assign out_flags = fl[QUO_W];
  assign quo       = q[QUO_W];
  assign big       = bg[QUO_W];

endmodule
`default_nettype wire

@@ src/kld_log2.sv @@
`default_nettype none
module kld_log2 import kld_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DET_W-1:0] x,
  output logic [LOG_W-1:0] lg
);

  logic [1:0]       grp_c;
  logic [3:0]       pos_c;
  logic [DET_W-1:0] xn_c;
  logic [DET_W-1:0] xs1;
  logic [1:0]       grp1;

  logic [31:0]       m [0:LOG_FB];
  logic [LOG_FB-1:0] f [0:LOG_FB];
  logic [5:0]        e [0:LOG_FB];

  // coarse normalise by 16-bit group
  always_comb begin
    grp_c = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (x[16*k +: 16] != '0) grp_c = 2'(k);
    end
  end

  // fine normalise within the top group
  always_comb begin
    pos_c = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (xs1[48+k]) pos_c = 4'(k);
    end
    xn_c = xs1 << (~pos_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs1  <= x << {~grp_c, 4'b0000};
      grp1 <= grp_c;
      m[0] <= xn_c[DET_W-1:32];
      f[0] <= '0;
      e[0] <= {grp1, pos_c};
    end
  end

  for (genvar k = 1; k <= LOG_FB; k++) begin : g_sq
    logic [DET_W-1:0] sq;
    logic [32:0]      t;
    assign sq = DET_W'(m[k-1]) * DET_W'(m[k-1]);
    assign t  = sq[DET_W-1:31];

    always_ff @(posedge clk) begin
      if (en) begin
        m[k] <= t[32] ? t[32:1] : t[31:0];
        f[k] <= {f[k-1][LOG_FB-2:0], t[32]};
        e[k] <= e[k-1];
      end
    end
  end

  assign lg = {e[LOG_FB], f[LOG_FB]};

endmodule
`default_nettype wire

@@ src/kld_back.sv @@
`default_nettype none
module kld_back import kld_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  kld_flags_t       in_flags,
  input  logic [QUO_W-1:0] quo,
  input  logic             big,
  input  logic [LOG_W-1:0] lg,
  input  logic [LOG_W-1:0] lp,
  output logic             out_valid,
  output logic [IN_W-1:0]  divergence,
  output logic [1:0]       status
);

  localparam int PW  = LOG_W + LOG_FB;
  localparam int PSH = 2 * LOG_FB - FRAC_BITS;

  logic [LOG_W:0]   ld_c, ldn_c;
  logic [PW-1:0]    rnd_c;
  logic [SUM_W-1:0] ln_c, tmp_c, half_c;
  logic             sat_c;

  logic             v1, v2, v3;
  kld_flags_t       fl1, fl2, fl3;
  logic [QUO_W-1:0] r1, r2;
  logic [LOG_W-1:0] mag1;
  logic             neg1, neg2;
  logic [PW-1:0]    prod2;
  logic [SUM_W-1:0] s3;

  always_comb begin
    ld_c   = {1'b0, lg} - {1'b0, lp};
    ldn_c  = -ld_c;
    rnd_c  = (prod2 + (PW'(1) << (PSH - 1))) >> PSH;
    ln_c   = neg2 ? -SUM_W'(rnd_c) : SUM_W'(rnd_c);
    tmp_c  = s3 + {{(SUM_W-1){1'b0}}, s3[SUM_W-1]};
    half_c = {tmp_c[SUM_W-1], tmp_c[SUM_W-1:1]};
    sat_c  = !((&half_c[SUM_W-1:IN_W-1]) || !(|half_c[SUM_W-1:IN_W-1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1   <= (big || quo > R_CAP) ? R_CAP : quo;
      mag1 <= ld_c[LOG_W] ? ldn_c[LOG_W-1:0] : ld_c[LOG_W-1:0];
      neg1 <= ld_c[LOG_W];
      fl1  <= in_flags;

      prod2 <= PW'(mag1) * PW'(LN2_Q28);
      neg2  <= neg1;
      r2    <= r1;
      fl2   <= fl1;

      s3  <= ln_c + SUM_W'(r2) - (SUM_W'(2) << FRAC_BITS);
      fl3 <= fl2;

      if (fl3.nofix) begin
        divergence <= '0;
        status     <= ST_NOFIX;
      end else if (fl3.nonpd) begin
        divergence <= '0;
        status     <= ST_NONPD;
      end else if (sat_c) begin
        divergence <= half_c[SUM_W-1] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
        status     <= ST_SAT;
      end else begin
        divergence <= half_c[IN_W-1:0];
        status     <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/gaussian_kl_divergence_2d_core.sv @@
`default_nettype none
// throughput: one word per cycle; set by the 37-stage quotient pipeline and
// the 28-stage log2 squaring pipelines, which all advance together
// a stalled output holds the whole pipeline
// reset (rst, synchronous) clears all valid bits; data registers are not reset
module gaussian_kl_divergence_2d_core import kld_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] pf_mean_x,
  input  logic signed [IN_W-1:0] pf_mean_y,
  input  logic        [IN_W-1:0] pf_var_x,
  input  logic        [IN_W-1:0] pf_var_y,
  input  logic signed [IN_W-1:0] pf_cov_xy,
  input  logic signed [IN_W-1:0] fix_mean_x,
  input  logic signed [IN_W-1:0] fix_mean_y,
  input  logic        [IN_W-1:0] fix_var_x,
  input  logic        [IN_W-1:0] fix_var_y,
  input  logic signed [IN_W-1:0] fix_cov_xy,
  input  logic                   fix_valid,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [IN_W-1:0] divergence,
  output logic        [1:0]      status
);

  logic             en;
  logic             f_valid, d_valid, d_big;
  kld_flags_t       f_flags, d_flags;
  logic [NUM_W-1:0] f_num;
  logic [DET_W-1:0] f_detg, f_detp;
  logic [QUO_W-1:0] d_quo;
  logic [LOG_W-1:0] lg_raw, lp_raw;
  logic [LOG_W-1:0] lg_dly [0:LOG_DLY-1];
  logic [LOG_W-1:0] lp_dly [0:LOG_DLY-1];
  logic [IN_W-1:0]  div_w;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  kld_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .pf_mean_x  (pf_mean_x),
    .pf_mean_y  (pf_mean_y),
    .pf_var_x   (pf_var_x),
    .pf_var_y   (pf_var_y),
    .pf_cov_xy  (pf_cov_xy),
    .fix_mean_x (fix_mean_x),
    .fix_mean_y (fix_mean_y),
    .fix_var_x  (fix_var_x),
    .fix_var_y  (fix_var_y),
    .fix_cov_xy (fix_cov_xy),
    .fix_valid  (fix_valid),
    .out_valid  (f_valid),
    .out_flags  (f_flags),
    .num        (f_num),
    .detg       (f_detg),
    .detp       (f_detp)
  );

  kld_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_flags  (f_flags),
    .num       (f_num),
    .den       (f_detg),
    .out_valid (d_valid),
    .out_flags (d_flags),
    .quo       (d_quo),
    .big       (d_big)
  );

  kld_log2 u_log_g (
    .clk (clk),
    .en  (en),
    .x   (f_detg),
    .lg  (lg_raw)
  );

  kld_log2 u_log_p (
    .clk (clk),
    .en  (en),
    .x   (f_detp),
    .lg  (lp_raw)
  );

  // line up the logs with the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      lg_dly[0] <= lg_raw;
      lp_dly[0] <= lp_raw;
      for (int k = 1; k < LOG_DLY; k++) begin
        lg_dly[k] <= lg_dly[k-1];
        lp_dly[k] <= lp_dly[k-1];
      end
    end
  end

  kld_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (d_valid),
    .in_flags   (d_flags),
    .quo        (d_quo),
    .big        (d_big),
    .lg         (lg_dly[LOG_DLY-1]),
    .lp         (lp_dly[LOG_DLY-1]),
    .out_valid  (out_valid),
    .divergence (div_w),
    .status     (status)
  );

  assign divergence = div_w;

endmodule
`default_nettype wire
